// ===== rtl/core/mac_address_text_parser_top_assert.svh =====
// Assertion macros for the MAC address text parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MAC_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH
`define MAC_ADDRESS_TEXT_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

// ===== rtl/core/mtp_pkg.sv =====
package mtp_pkg;

    localparam int ADDR_W = 48;
    localparam int CHAR_W = 8;
    localparam int ACC_W  = 9;
    localparam int CNT_W  = 3;
    localparam int ERR_W  = 3;

    localparam logic [CNT_W-1:0] OCTETS_PER_ADDR = 3'd6;
    localparam logic [ACC_W-1:0] OCTET_MAX       = 9'h0ff;
    localparam logic [ACC_W-1:0] OCTET_SAT       = 9'h100;

    // Delimiter characters.
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;

    // Reported error codes, in order of precedence after success.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_CHAR = 3'd1,
        ERR_TOO_MANY = 3'd2,
        ERR_OVER     = 3'd3,
        ERR_TOO_FEW  = 3'd4
    } err_code_t;

    // First octet error recorded during a string.
    typedef enum logic [1:0] {
        PE_NONE     = 2'd0,
        PE_TOO_MANY = 2'd1,
        PE_OVER     = 2'd2
    } parse_err_t;

    typedef struct packed {
        logic [ADDR_W-1:0] store;
        logic [CNT_W-1:0]  count;
        logic              in_token;
        logic [ACC_W-1:0]  accum;
        parse_err_t        perr;
        logic              bad;
    } parse_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        err_code_t         error_code;
        logic              multicast;
        logic              local_admin;
        logic              broadcast;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        store:    '0,
        count:    '0,
        in_token: 1'b0,
        accum:    '0,
        perr:     PE_NONE,
        bad:      1'b0
    };

    // Ends an open run of digits: the octet is checked and stored.
    function automatic parse_state_t close_token(parse_state_t s);
        parse_state_t n;
        n = s;
        if (s.in_token)
        begin
            n.in_token = 1'b0;
            if (s.perr == PE_NONE)
            begin
                if (s.accum > OCTET_MAX)
                begin
                    n.perr = PE_OVER;
                end
                else if (s.count < OCTETS_PER_ADDR)
                begin
                    n.store = {s.store[ADDR_W-9:0], s.accum[7:0]};
                    n.count = s.count + 3'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/mac_address_text_parser_top.sv =====
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+---------------------------------
// char     | in        | char_valid / char_stall   | character, final_char
// result   | out       | result_valid / result_stall | address, error_code, flags
//
// One character word is taken every cycle while char_stall is low; the result word
// is loaded into the result register when the marked final character moves on from
// the input register. The rate is set by the combinational parse step between the
// input register and the parse state registers.
// Reset is asynchronous and active low; it clears all control and parse state.
// char_stall rises only while a final character waits behind a stalled result word.
`include "mac_address_text_parser_top_assert.svh"

module mac_address_text_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  character,
    input  logic        final_char,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [47:0] address,
    output logic [2:0]  error_code,
    output logic        multicast,
    output logic        local_admin,
    output logic        broadcast
);
    import mtp_pkg::*;

    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic [CHAR_W-1:0] hold_char_reg;
    logic              hold_final_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    result_t           step_result;
    logic              out_free;
    logic              advance;
    logic              accept;

    // A held word moves on unless it is final and the result register cannot take it.
    assign advance    = hold_valid_reg && (!hold_final_reg || out_free);
    assign char_stall = hold_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    // Input register and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            state_reg      <= STATE_RESET;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_char_reg  <= character;
            hold_final_reg <= final_char;
        end
    end

    // Parse step for the held character.
    mtp_step u_step
    (
        .state_q    (state_reg),
        .character  (hold_char_reg),
        .final_char (hold_final_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Result register.
    mtp_out_reg u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && hold_final_reg),
        .load_data    (step_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .address      (address),
        .error_code   (error_code),
        .multicast    (multicast),
        .local_admin  (local_admin),
        .broadcast    (broadcast)
    );

    // Checks on the parse logic.
    `MTP_ASSERT_IMP(a_err_zero_addr, result_valid && error_code != ERR_NONE, address == '0)
    `MTP_ASSERT_IMP(a_count_range, 1'b1, state_reg.count <= OCTETS_PER_ADDR)
    `MTP_ASSERT_NXT(a_final_gives_result, advance && hold_final_reg, result_valid)
    `MTP_ASSERT_NXT(a_final_clears_state, advance && hold_final_reg, state_reg == STATE_RESET)

endmodule

// ===== rtl/core/mtp_step.sv =====
module mtp_step
(
    input  mtp_pkg::parse_state_t  state_q,
    input  logic [7:0]             character,
    input  logic                   final_char,
    output mtp_pkg::parse_state_t  state_next,
    output mtp_pkg::result_t       result
);
    import mtp_pkg::*;

    logic         is_hex;
    logic         is_delim;
    logic [3:0]   digit_val;
    parse_state_t after_char;
    parse_state_t closed;
    err_code_t    code;
    logic [ADDR_W-1:0] addr;

    // Classify the character and work out its digit value.
    always_comb
    begin
        is_hex    = 1'b1;
        digit_val = 4'd0;
        if (character inside {[8'h30:8'h39]})
        begin
            digit_val = character[3:0];
        end
        else if (character inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            digit_val = character[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
        is_delim = (character == CH_DASH) || (character == CH_COLON)
                   || (character == CH_DOT);
    end

    // Apply the character to the parse state.
    always_comb
    begin
        after_char = state_q;
        if (is_hex)
        begin
            if (!state_q.in_token)
            begin
                after_char.in_token = 1'b1;
                after_char.accum    = {5'd0, digit_val};
                if (state_q.perr == PE_NONE && state_q.count >= OCTETS_PER_ADDR)
                begin
                    after_char.perr = PE_TOO_MANY;
                end
            end
            else if (state_q.accum[ACC_W-1:4] != '0)
            begin
                // A further digit pushes the value beyond 0xff.
                after_char.accum = OCTET_SAT;
            end
            else
            begin
                after_char.accum = {1'b0, state_q.accum[3:0], digit_val};
            end
        end
        else if (is_delim)
        begin
            after_char = close_token(state_q);
        end
        else
        begin
            after_char.bad = 1'b1;
        end
    end

    // Close the last run and grade the string.
    always_comb
    begin
        closed = close_token(after_char);
        if (closed.bad)
        begin
            code = ERR_BAD_CHAR;
        end
        else if (closed.perr == PE_TOO_MANY)
        begin
            code = ERR_TOO_MANY;
        end
        else if (closed.perr != PE_NONE)
        begin
            code = ERR_OVER;
        end
        else if (closed.count != OCTETS_PER_ADDR)
        begin
            code = ERR_TOO_FEW;
        end
        else
        begin
            code = ERR_NONE;
        end
        addr = (code == ERR_NONE) ? closed.store : '0;
    end

    // The state starts afresh after the last character of a string.
    always_comb
    begin
        state_next         = final_char ? STATE_RESET : after_char;
        result.address     = addr;
        result.error_code  = code;
        result.multicast   = addr[ADDR_W-8];
        result.local_admin = addr[ADDR_W-7];
        result.broadcast   = (addr == {ADDR_W{1'b1}});
    end

endmodule

// ===== rtl/core/mtp_out_reg.sv =====
module mtp_out_reg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  mtp_pkg::result_t           load_data,
    output logic                       free,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [47:0]                address,
    output logic [2:0]                 error_code,
    output logic                       multicast,
    output logic                       local_admin,
    output logic                       broadcast
);
    import mtp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new word when empty or being emptied.
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign address      = data_reg.address;
    assign error_code   = data_reg.error_code;
    assign multicast    = data_reg.multicast;
    assign local_admin  = data_reg.local_admin;
    assign broadcast    = data_reg.broadcast;

endmodule
